/* hdl/pts_pkg.sv */
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Operation, result and task-state codes used by the scheduler and its testbench.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_F_W = 4;
    localparam int PRIO_F_W = 3;
    localparam int TICKS_W  = 16;
    localparam int STAT_W   = 2;
    localparam int ID_W     = 32;
    localparam int SLICE_W  = 8;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 40;

    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
    localparam logic [OP_W-1:0] OP_SLEEP  = 3'd5;

    localparam logic [STAT_W-1:0] RES_OK      = 2'd0;
    localparam logic [STAT_W-1:0] RES_NONE    = 2'd1;
    localparam logic [STAT_W-1:0] RES_IGNORED = 2'd2;

    localparam logic [1:0] TS_DEAD     = 2'd0;
    localparam logic [1:0] TS_READY    = 2'd1;
    localparam logic [1:0] TS_RUNNING  = 2'd2;
    localparam logic [1:0] TS_SLEEPING = 2'd3;

endpackage

/* hdl/pts_task_ram.sv */
// ----------------------------------------------------------------------------
// Task record memory
// Synchronous single-port-write, single-read memory with registered read
// data. Entries never written since reset read back as the reset record.
// ----------------------------------------------------------------------------
module pts_task_ram #(
    parameter int              DEPTH      = 16,
    parameter int              WIDTH      = 66,
    parameter logic [WIDTH-1:0] RESET_WORD = '0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_word_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : RESET_WORD;

endmodule

/* hdl/priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// Priority task scheduler
// Fixed-priority, round-robin scheduler over a pool of task records kept in
// one synchronous memory, with per-priority FIFO ready queues linked through
// the pool.
// ----------------------------------------------------------------------------
// Add, remove and sleep take longer for each queue entry walked. Alloc and
// tick scan the task pool slot by slot; a tick takes longest when every task
// wakes and the current slice ends. Any operation may also wait for the output.
// A new request is taken only in the idle state, once the last one is done;
// the result register lets a new transaction be accepted while the previous
// result waits.
// Reset (rst_n, asynchronous, active low) makes all tasks dead, all queues
// empty, no current task, the id counter zero and the time slice ten.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
    parameter int TASKS      = 16,
    parameter int PRIORITIES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: default time slice.
    input  logic                          cfg_wen,
    input  logic [pts_pkg::SLICE_W-1:0]   cfg_wdata,
    // Requests. tdata from bit 0: operation[2:0], task_slot[6:3],
    // task_priority[9:7], sleep_ticks[25:10], zero padding.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pts_pkg::IN_W-1:0]      s_tdata,
    // Results. tdata from bit 0: status[1:0], chosen_slot[5:2],
    // chosen_id[37:6], slice_expired[38], zero padding.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pts_pkg::OUT_W-1:0]     m_tdata
);

    import pts_pkg::*;

    // Index widths. A null pointer is encoded as TASKS.
    localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int NIL_W  = $clog2(TASKS + 1);
    localparam int PRIO_W = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
    localparam logic [NIL_W-1:0]  NIL       = NIL_W'(TASKS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASKS - 1);

    // Task record layout, from bit 0: status, priority, id, delay, slice, next.
    localparam int PRIO_OFF  = 2;
    localparam int ID_OFF    = PRIO_OFF + PRIO_W;
    localparam int DELAY_OFF = ID_OFF + ID_W;
    localparam int SLICE_OFF = DELAY_OFF + TICKS_W;
    localparam int NEXT_OFF  = SLICE_OFF + SLICE_W;
    localparam int REC_W     = NEXT_OFF + NIL_W;
    localparam logic [REC_W-1:0] REC_RESET = REC_W'(NIL) << NEXT_OFF;

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_AL_RD    = 5'd2;
    localparam logic [4:0] S_AL_CHK   = 5'd3;
    localparam logic [4:0] S_LOC_T    = 5'd4;
    localparam logic [4:0] S_LOC_TD   = 5'd5;
    localparam logic [4:0] S_LOC_RD   = 5'd6;
    localparam logic [4:0] S_LOC_NX   = 5'd7;
    localparam logic [4:0] S_LOC_DONE = 5'd8;
    localparam logic [4:0] S_ADD_W    = 5'd9;
    localparam logic [4:0] S_SLP_W    = 5'd10;
    localparam logic [4:0] S_RM1      = 5'd11;
    localparam logic [4:0] S_RM2      = 5'd12;
    localparam logic [4:0] S_RM3      = 5'd13;
    localparam logic [4:0] S_SEL      = 5'd14;
    localparam logic [4:0] S_SEL_DQ   = 5'd15;
    localparam logic [4:0] S_SEL_CUR  = 5'd16;
    localparam logic [4:0] S_TK_RD    = 5'd17;
    localparam logic [4:0] S_TK_CHK   = 5'd18;
    localparam logic [4:0] S_TK_NEXT  = 5'd19;
    localparam logic [4:0] S_TK_CUR   = 5'd20;
    localparam logic [4:0] S_TK_CC    = 5'd21;
    localparam logic [4:0] S_PUSH     = 5'd22;
    localparam logic [4:0] S_PUSH_W   = 5'd23;
    localparam logic [4:0] S_RESP     = 5'd24;

    logic [4:0]          state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [SLOT_F_W-1:0] slot_reg;
    logic [PRIO_F_W-1:0] prio_reg;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [NIL_W-1:0]    cur_reg;
    logic [NIL_W-1:0]    prev_reg;
    logic [NIL_W-1:0]    steps_reg;
    logic                found_reg;
    logic [REC_W-1:0]    trec_reg;
    logic [SLOT_W-1:0]   push_slot_reg;
    logic [PRIO_W-1:0]   push_prio_reg;
    logic [4:0]          ret_reg;
    logic [NIL_W-1:0]    head_reg [PRIORITIES];
    logic [NIL_W-1:0]    tail_reg [PRIORITIES];
    logic [NIL_W-1:0]    current_reg;
    logic [ID_W-1:0]     id_cnt_reg;
    logic [SLICE_W-1:0]  slice_cfg_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic [SLOT_F_W-1:0] res_slot_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic                res_exp_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    // Memory port signals.
    logic [SLOT_W-1:0]   rd_addr;
    logic [REC_W-1:0]    rd_word;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [REC_W-1:0]    wr_word;

    // Fields of the word just read and of the held target record.
    logic [1:0]          rd_status;
    logic [PRIO_W-1:0]   rd_prio;
    logic [ID_W-1:0]     rd_id;
    logic [TICKS_W-1:0]  rd_delay;
    logic [SLICE_W-1:0]  rd_slice;
    logic [NIL_W-1:0]    rd_next;
    logic [PRIO_W-1:0]   t_prio;
    logic [NIL_W-1:0]    t_next;

    logic [1:0]          wr_status;
    logic [PRIO_W-1:0]   wr_prio;
    logic [ID_W-1:0]     wr_id;
    logic [TICKS_W-1:0]  wr_delay;
    logic [SLICE_W-1:0]  wr_slice;
    logic [NIL_W-1:0]    wr_next;

    logic [SLOT_W-1:0]   slot_idx;
    logic                slot_ok;
    logic                prio_ok;
    logic [TICKS_W-1:0]  delay_dec;
    logic [SLICE_W-1:0]  slice_dec;
    logic [PRIO_W-1:0]   sel_p;
    logic                sel_hit;

    assign rd_status = rd_word[1:0];
    assign rd_prio   = rd_word[PRIO_OFF +: PRIO_W];
    assign rd_id     = rd_word[ID_OFF +: ID_W];
    assign rd_delay  = rd_word[DELAY_OFF +: TICKS_W];
    assign rd_slice  = rd_word[SLICE_OFF +: SLICE_W];
    assign rd_next   = rd_word[NEXT_OFF +: NIL_W];
    assign t_prio    = trec_reg[PRIO_OFF +: PRIO_W];
    assign t_next    = trec_reg[NEXT_OFF +: NIL_W];

    assign slot_idx  = SLOT_W'(slot_reg);
    assign slot_ok   = 32'(slot_reg) < TASKS;
    assign prio_ok   = 32'(prio_reg) < PRIORITIES;
    assign delay_dec = (rd_delay != '0) ? rd_delay - 1'b1 : rd_delay;
    assign slice_dec = (rd_slice != '0) ? rd_slice - 1'b1 : rd_slice;

    // Highest non-empty queue; priority 0 wins.
    always_comb
    begin
        sel_p   = '0;
        sel_hit = 1'b0;
        for (int i = PRIORITIES - 1; i >= 0; i--)
        begin
            if (head_reg[i] != NIL)
            begin
                sel_p   = PRIO_W'(i);
                sel_hit = 1'b1;
            end
        end
    end

    // Read address for the record needed in the following state.
    always_comb
    begin
        unique case (state_reg)
            S_LOC_T:  rd_addr = slot_idx;
            S_LOC_RD: rd_addr = cur_reg[SLOT_W-1:0];
            S_RM1:    rd_addr = prev_reg[SLOT_W-1:0];
            S_SEL:    rd_addr = sel_hit ? head_reg[sel_p][SLOT_W-1:0]
                                        : current_reg[SLOT_W-1:0];
            S_TK_CUR: rd_addr = current_reg[SLOT_W-1:0];
            S_PUSH:   rd_addr = tail_reg[push_prio_reg][SLOT_W-1:0];
            default:  rd_addr = idx_reg;
        endcase
    end

    // Record updates: each is a read-modify-write of a word read the cycle
    // before, or of the held target record. A read never follows a write to
    // the same entry in the same cycle, so no forwarding is needed.
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_status = rd_status;
        wr_prio   = rd_prio;
        wr_id     = rd_id;
        wr_delay  = rd_delay;
        wr_slice  = rd_slice;
        wr_next   = rd_next;
        unique case (state_reg)
            S_AL_CHK:
            begin
                wr_en = (rd_status == TS_DEAD);
                wr_id = id_cnt_reg;
            end
            S_ADD_W, S_SLP_W, S_RM3:
            begin
                wr_en     = 1'b1;
                wr_addr   = slot_idx;
                wr_status = trec_reg[1:0];
                wr_prio   = t_prio;
                wr_id     = trec_reg[ID_OFF +: ID_W];
                wr_delay  = trec_reg[DELAY_OFF +: TICKS_W];
                wr_slice  = trec_reg[SLICE_OFF +: SLICE_W];
                wr_next   = t_next;
                if (state_reg == S_ADD_W)
                begin
                    wr_prio   = PRIO_W'(prio_reg);
                    wr_status = TS_READY;
                    wr_slice  = slice_cfg_reg;
                    wr_next   = NIL;
                end
                else if (state_reg == S_SLP_W)
                begin
                    wr_status = TS_SLEEPING;
                    wr_delay  = ticks_reg;
                end
                else
                begin
                    wr_next = NIL;
                end
            end
            S_RM2:
            begin
                wr_en   = 1'b1;
                wr_addr = prev_reg[SLOT_W-1:0];
                wr_next = t_next;
            end
            S_SEL_DQ:
            begin
                wr_en     = 1'b1;
                wr_addr   = cur_reg[SLOT_W-1:0];
                wr_status = TS_RUNNING;
                wr_slice  = slice_cfg_reg;
                wr_next   = NIL;
            end
            S_TK_CHK:
            begin
                wr_en    = (rd_status == TS_SLEEPING);
                wr_delay = delay_dec;
                if (delay_dec == '0)
                begin
                    wr_status = TS_READY;
                    wr_next   = NIL;
                end
            end
            S_TK_CC:
            begin
                wr_en    = (rd_status == TS_RUNNING);
                wr_addr  = current_reg[SLOT_W-1:0];
                wr_slice = slice_dec;
                if (slice_dec == '0)
                begin
                    wr_status = TS_READY;
                    wr_next   = NIL;
                end
            end
            S_PUSH_W:
            begin
                wr_en   = 1'b1;
                wr_addr = tail_reg[push_prio_reg][SLOT_W-1:0];
                wr_next = NIL_W'(push_slot_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign wr_word = {wr_next, wr_slice, wr_delay, wr_id, wr_prio, wr_status};

    pts_task_ram #(
        .DEPTH      (TASKS),
        .WIDTH      (REC_W),
        .RESET_WORD (REC_RESET)
    ) u_task_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            current_reg   <= NIL;
            id_cnt_reg    <= '0;
            slice_cfg_reg <= SLICE_W'(10);
            m_tvalid_reg  <= 1'b0;
            for (int p = 0; p < PRIORITIES; p++)
            begin
                head_reg[p] <= NIL;
                tail_reg[p] <= NIL;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                slice_cfg_reg <= cfg_wdata;
            end
            // The response state loads the output register itself.
            if (m_tvalid_reg && m_tready && state_reg != S_RESP)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tdata[2:0];
                        slot_reg  <= s_tdata[6:3];
                        prio_reg  <= s_tdata[9:7];
                        ticks_reg <= s_tdata[25:10];
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    res_status_reg <= RES_OK;
                    res_slot_reg   <= '0;
                    res_id_reg     <= '0;
                    res_exp_reg    <= 1'b0;
                    idx_reg        <= '0;
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            state_reg <= S_AL_RD;
                        end
                        OP_ADD:
                        begin
                            if (slot_ok && prio_ok)
                            begin
                                state_reg <= S_LOC_T;
                            end
                            else
                            begin
                                res_status_reg <= RES_IGNORED;
                                state_reg      <= S_RESP;
                            end
                        end
                        OP_REMOVE, OP_SLEEP:
                        begin
                            if (slot_ok)
                            begin
                                state_reg <= S_LOC_T;
                            end
                            else
                            begin
                                res_status_reg <= RES_IGNORED;
                                state_reg      <= S_RESP;
                            end
                        end
                        OP_SELECT:
                        begin
                            state_reg <= S_SEL;
                        end
                        OP_TICK:
                        begin
                            state_reg <= S_TK_RD;
                        end
                        default:
                        begin
                            res_status_reg <= RES_IGNORED;
                            state_reg      <= S_RESP;
                        end
                    endcase
                end

                // Alloc: scan for the lowest dead slot.
                S_AL_RD:
                begin
                    state_reg <= S_AL_CHK;
                end
                S_AL_CHK:
                begin
                    if (rd_status == TS_DEAD)
                    begin
                        res_slot_reg <= SLOT_F_W'(idx_reg);
                        res_id_reg   <= id_cnt_reg;
                        id_cnt_reg   <= id_cnt_reg + 1'b1;
                        state_reg    <= S_RESP;
                    end
                    else if (idx_reg == LAST_SLOT)
                    begin
                        res_status_reg <= RES_NONE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_AL_RD;
                    end
                end

                // Locate: walk the queue of the task's stored priority.
                S_LOC_T:
                begin
                    state_reg <= S_LOC_TD;
                end
                S_LOC_TD:
                begin
                    trec_reg  <= rd_word;
                    cur_reg   <= head_reg[rd_prio];
                    prev_reg  <= NIL;
                    steps_reg <= '0;
                    state_reg <= S_LOC_RD;
                end
                S_LOC_RD:
                begin
                    if (cur_reg == NIL || steps_reg == NIL)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_LOC_DONE;
                    end
                    else if (cur_reg == NIL_W'(slot_idx))
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_LOC_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LOC_NX;
                    end
                end
                S_LOC_NX:
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= rd_next;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_LOC_RD;
                end
                S_LOC_DONE:
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        if (found_reg)
                        begin
                            state_reg <= S_RM1;
                        end
                        else
                        begin
                            res_status_reg <= RES_IGNORED;
                            state_reg      <= S_RESP;
                        end
                    end
                    else if (found_reg)
                    begin
                        res_status_reg <= RES_IGNORED;
                        state_reg      <= S_RESP;
                    end
                    else if (op_reg == OP_ADD)
                    begin
                        state_reg <= S_ADD_W;
                    end
                    else
                    begin
                        state_reg <= S_SLP_W;
                    end
                end

                S_ADD_W:
                begin
                    push_slot_reg <= slot_idx;
                    push_prio_reg <= PRIO_W'(prio_reg);
                    ret_reg       <= S_RESP;
                    state_reg     <= S_PUSH;
                end
                S_SLP_W:
                begin
                    state_reg <= S_RESP;
                end

                // Remove: relink the predecessor or the head, fix the tail.
                S_RM1:
                begin
                    if (prev_reg == NIL)
                    begin
                        head_reg[t_prio] <= t_next;
                        state_reg        <= S_RM3;
                    end
                    else
                    begin
                        state_reg <= S_RM2;
                    end
                end
                S_RM2:
                begin
                    state_reg <= S_RM3;
                end
                S_RM3:
                begin
                    if (tail_reg[t_prio] == NIL_W'(slot_idx))
                    begin
                        tail_reg[t_prio] <= prev_reg;
                    end
                    state_reg <= S_RESP;
                end

                // Select: dequeue the best head, or report the current task.
                S_SEL:
                begin
                    if (sel_hit)
                    begin
                        cur_reg   <= head_reg[sel_p];
                        state_reg <= S_SEL_DQ;
                    end
                    else if (current_reg != NIL)
                    begin
                        state_reg <= S_SEL_CUR;
                    end
                    else
                    begin
                        res_status_reg <= RES_NONE;
                        state_reg      <= S_RESP;
                    end
                end
                S_SEL_DQ:
                begin
                    head_reg[rd_prio] <= rd_next;
                    if (rd_next == NIL)
                    begin
                        tail_reg[rd_prio] <= NIL;
                    end
                    current_reg  <= cur_reg;
                    res_slot_reg <= SLOT_F_W'(cur_reg[SLOT_W-1:0]);
                    res_id_reg   <= rd_id;
                    state_reg    <= S_RESP;
                end
                S_SEL_CUR:
                begin
                    res_slot_reg <= SLOT_F_W'(current_reg[SLOT_W-1:0]);
                    res_id_reg   <= rd_id;
                    state_reg    <= S_RESP;
                end

                // Tick: wake sleepers in slot order, then age the current task.
                S_TK_RD:
                begin
                    state_reg <= S_TK_CHK;
                end
                S_TK_CHK:
                begin
                    if (rd_status == TS_SLEEPING && delay_dec == '0)
                    begin
                        push_slot_reg <= idx_reg;
                        push_prio_reg <= rd_prio;
                        ret_reg       <= S_TK_NEXT;
                        state_reg     <= S_PUSH;
                    end
                    else
                    begin
                        state_reg <= S_TK_NEXT;
                    end
                end
                S_TK_NEXT:
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= S_TK_CUR;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TK_RD;
                    end
                end
                S_TK_CUR:
                begin
                    state_reg <= (current_reg != NIL) ? S_TK_CC : S_RESP;
                end
                S_TK_CC:
                begin
                    if (rd_status == TS_RUNNING && slice_dec == '0)
                    begin
                        res_exp_reg   <= 1'b1;
                        push_slot_reg <= current_reg[SLOT_W-1:0];
                        push_prio_reg <= rd_prio;
                        ret_reg       <= S_RESP;
                        state_reg     <= S_PUSH;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end

                // Append push_slot to the tail of its queue.
                S_PUSH:
                begin
                    if (tail_reg[push_prio_reg] == NIL)
                    begin
                        head_reg[push_prio_reg] <= NIL_W'(push_slot_reg);
                        tail_reg[push_prio_reg] <= NIL_W'(push_slot_reg);
                        state_reg               <= ret_reg;
                    end
                    else
                    begin
                        state_reg <= S_PUSH_W;
                    end
                end
                S_PUSH_W:
                begin
                    tail_reg[push_prio_reg] <= NIL_W'(push_slot_reg);
                    state_reg               <= ret_reg;
                end

                // Hand the result to the output register once it is free.
                S_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, res_exp_reg, res_id_reg,
                                         res_slot_reg, res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives request transactions through the streaming slave port from a queue
// of pending requests. A shadow scheduler computes the result of each request
// as it is queued, and a monitor compares each result transaction, field by
// field, with the oldest one still outstanding. The sender works in random
// bursts and the receiver stalls at random, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import pts_pkg::*;

    localparam int TASKS      = 16;
    localparam int PRIORITIES = 8;
    localparam int NIL        = TASKS;

    // Operation codes that the block does not implement.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // Cycles without any transaction before the run is declared hung. This
    // covers the long receiver hold-off plus the slowest tick.
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLDOFF_LEN  = 400;
    localparam int HOLDOFF_AT   = 4000;
    localparam int SETTLE_TIME  = 120;
    localparam int RANDOM_ITEMS = 1320;

    typedef struct packed {
        logic                 expired;
        logic [ID_W-1:0]      id;
        logic [SLOT_F_W-1:0]  slot;
        logic [STAT_W-1:0]    status;
    } sched_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [SLICE_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;

    priority_task_scheduler #(
        .TASKS      (TASKS),
        .PRIORITIES (PRIORITIES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow scheduler state. It is advanced as each request is queued; the
    // block handles requests strictly in order, so the results line up.
    // ------------------------------------------------------------------------
    logic [1:0]          sh_status [TASKS];
    logic [PRIO_F_W-1:0] sh_prio   [TASKS];
    logic [ID_W-1:0]     sh_ident  [TASKS];
    logic [TICKS_W-1:0]  sh_delay  [TASKS];
    logic [SLICE_W-1:0]  sh_slice  [TASKS];
    int                  sh_next   [TASKS];
    int                  sh_head   [PRIORITIES];
    int                  sh_tail   [PRIORITIES];
    int                  sh_current;
    logic [ID_W-1:0]     sh_id_count;
    logic [SLICE_W-1:0]  sh_slice_cfg;
    // A slot whose id has been written by an alloc; only such slots are ever
    // added or put to sleep, so no unwritten id can reach a select.
    bit                  id_written [TASKS];

    logic [IN_W-1:0]     pending_requests [$];
    sched_result_t       awaited_results [$];
    int                  mismatches;

    function automatic void enqueue_tail(int t);
        int p;
        p = int'(sh_prio[t]);
        sh_next[t] = NIL;
        if (sh_tail[p] != NIL)
            sh_next[sh_tail[p]] = t;
        else
            sh_head[p] = t;
        sh_tail[p] = t;
    endfunction

    // Finds slot t in the queue of its priority, returning its predecessor.
    function automatic bit find_queued(int t, output int prev);
        int cur;
        int p;
        p    = int'(sh_prio[t]);
        prev = NIL;
        cur  = sh_head[p];
        for (int n = 0; n < TASKS && cur != NIL; n++)
        begin
            if (cur == t)
                return 1'b1;
            prev = cur;
            cur  = sh_next[cur];
        end
        prev = NIL;
        return 1'b0;
    endfunction

    function automatic sched_result_t sched_predict(logic [OP_W-1:0] op, int slot,
                                                    int prio, logic [TICKS_W-1:0] ticks);
        sched_result_t r;
        int            prev;
        int            h;
        int            p;
        r = '0;
        case (op)
            OP_ALLOC:
            begin
                r.status = RES_NONE;
                for (int i = 0; i < TASKS; i++)
                begin
                    if (sh_status[i] == TS_DEAD)
                    begin
                        sh_ident[i]   = sh_id_count;
                        id_written[i] = 1'b1;
                        sh_id_count   = sh_id_count + 1'b1;
                        r.status      = RES_OK;
                        r.slot        = SLOT_F_W'(i);
                        r.id          = sh_ident[i];
                        break;
                    end
                end
            end
            OP_ADD:
            begin
                if (find_queued(slot, prev))
                    r.status = RES_IGNORED;
                else
                begin
                    sh_prio[slot]   = PRIO_F_W'(prio);
                    sh_status[slot] = TS_READY;
                    sh_slice[slot]  = sh_slice_cfg;
                    enqueue_tail(slot);
                end
            end
            OP_REMOVE:
            begin
                if (!find_queued(slot, prev))
                    r.status = RES_IGNORED;
                else
                begin
                    p = int'(sh_prio[slot]);
                    if (prev == NIL)
                        sh_head[p] = sh_next[slot];
                    else
                        sh_next[prev] = sh_next[slot];
                    if (sh_tail[p] == slot)
                        sh_tail[p] = prev;
                    sh_next[slot] = NIL;
                end
            end
            OP_SELECT:
            begin
                for (int i = 0; i < PRIORITIES; i++)
                begin
                    h = sh_head[i];
                    if (h != NIL)
                    begin
                        sh_head[i] = sh_next[h];
                        if (sh_head[i] == NIL)
                            sh_tail[i] = NIL;
                        sh_next[h]   = NIL;
                        sh_status[h] = TS_RUNNING;
                        sh_slice[h]  = sh_slice_cfg;
                        sh_current   = h;
                        break;
                    end
                end
                if (sh_current != NIL)
                begin
                    r.slot = SLOT_F_W'(sh_current);
                    r.id   = sh_ident[sh_current];
                end
                else
                    r.status = RES_NONE;
            end
            OP_TICK:
            begin
                // Sleepers wake in slot order, then the running task ages.
                for (int i = 0; i < TASKS; i++)
                begin
                    if (sh_status[i] == TS_SLEEPING)
                    begin
                        if (sh_delay[i] != 0)
                            sh_delay[i] = sh_delay[i] - 1'b1;
                        if (sh_delay[i] == 0)
                        begin
                            sh_status[i] = TS_READY;
                            enqueue_tail(i);
                        end
                    end
                end
                if (sh_current != NIL && sh_status[sh_current] == TS_RUNNING)
                begin
                    if (sh_slice[sh_current] != 0)
                        sh_slice[sh_current] = sh_slice[sh_current] - 1'b1;
                    if (sh_slice[sh_current] == 0)
                    begin
                        sh_status[sh_current] = TS_READY;
                        enqueue_tail(sh_current);
                        r.expired = 1'b1;
                    end
                end
            end
            OP_SLEEP:
            begin
                if (find_queued(slot, prev))
                    r.status = RES_IGNORED;
                else
                begin
                    sh_status[slot] = TS_SLEEPING;
                    sh_delay[slot]  = ticks;
                end
            end
            default:
                r.status = RES_IGNORED;
        endcase
        return r;
    endfunction

    // Queues one request and its predicted result; returns the prediction.
    function automatic sched_result_t issue(logic [OP_W-1:0] op, int slot, int prio,
                                            logic [TICKS_W-1:0] ticks);
        sched_result_t r;
        r = sched_predict(op, slot, prio, ticks);
        pending_requests.push_back({6'd0, ticks, prio[PRIO_F_W-1:0],
                                    slot[SLOT_F_W-1:0], op});
        awaited_results.push_back(r);
        return r;
    endfunction

    // Picks a slot that has had its id written, or -1 if there is none.
    function automatic int pick_written();
        int base;
        base = $urandom_range(0, TASKS - 1);
        for (int n = 0; n < TASKS; n++)
            if (id_written[(base + n) % TASKS])
                return (base + n) % TASKS;
        return -1;
    endfunction

    function automatic logic [TICKS_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return TICKS_W'($urandom_range(0, 4));
        else if (r < 9)
            return TICKS_W'($urandom_range(5, 40));
        return TICKS_W'($urandom());
    endfunction

    // One random request, mostly well-formed traffic on allocated tasks.
    task automatic random_request();
        sched_result_t r;
        int            w;
        int            sel;
        sel = $urandom_range(0, 99);
        w   = pick_written();
        if (sel < 8 || w < 0)
        begin
            r = issue(OP_ALLOC, $urandom_range(0, 15), $urandom_range(0, 7),
                      TICKS_W'($urandom()));
            // Usually put a fresh task straight into service.
            if (r.status == RES_OK && $urandom_range(0, 9) < 7)
                r = issue(OP_ADD, int'(r.slot), $urandom_range(0, 7), TICKS_W'($urandom()));
        end
        else if (sel < 30)
            r = issue(OP_ADD, w, $urandom_range(0, 7), TICKS_W'($urandom()));
        else if (sel < 42)
            r = issue(OP_REMOVE, $urandom_range(0, 15), $urandom_range(0, 7),
                      TICKS_W'($urandom()));
        else if (sel < 62)
            r = issue(OP_SELECT, $urandom_range(0, 15), $urandom_range(0, 7),
                      TICKS_W'($urandom()));
        else if (sel < 84)
            r = issue(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 7),
                      TICKS_W'($urandom()));
        else if (sel < 96)
            r = issue(OP_SLEEP, w, $urandom_range(0, 7), pick_delay());
        else
            r = issue($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                      $urandom_range(0, 15), $urandom_range(0, 7), TICKS_W'($urandom()));
    endtask

    // Lets every outstanding result arrive, then a little longer.
    task automatic drain();
        while (pending_requests.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
    endtask

    task automatic write_slice(logic [SLICE_W-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        sh_slice_cfg = value;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        sched_result_t       r;
        logic [SLICE_W-1:0]  slices [5];
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        mismatches = 0;
        for (int i = 0; i < TASKS; i++)
        begin
            sh_status[i]  = TS_DEAD;
            sh_prio[i]    = '0;
            sh_ident[i]   = '0;
            sh_delay[i]   = '0;
            sh_slice[i]   = '0;
            sh_next[i]    = NIL;
            id_written[i] = 1'b0;
        end
        for (int i = 0; i < PRIORITIES; i++)
        begin
            sh_head[i] = NIL;
            sh_tail[i] = NIL;
        end
        sh_current   = NIL;
        sh_id_count  = '0;
        sh_slice_cfg = 8'd10;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: an empty scheduler, queue ordering across the priority
        // extremes, ignored adds, removes and sleeps, wake-up on a zero delay,
        // a very long sleep and the spare operation codes.
        r = issue(OP_SELECT, 15, 7, 16'hFFFF);
        r = issue(OP_TICK,    0, 0, 16'h0000);
        r = issue(OP_ALLOC,   0, 0, 16'h0000);
        r = issue(OP_ADD,     0, 0, 16'h0000);
        r = issue(OP_ALLOC,   0, 0, 16'h0000);
        r = issue(OP_ADD,     1, 7, 16'h0000);
        r = issue(OP_ALLOC,   0, 0, 16'h0000);
        r = issue(OP_ADD,     2, 0, 16'h0000);
        r = issue(OP_ADD,     0, 3, 16'h0000);
        r = issue(OP_SLEEP,   2, 0, 16'h0005);
        r = issue(OP_SELECT,  0, 0, 16'h0000);
        r = issue(OP_REMOVE,  1, 0, 16'h0000);
        r = issue(OP_REMOVE,  1, 0, 16'h0000);
        r = issue(OP_REMOVE, 15, 7, 16'hFFFF);
        r = issue(OP_SLEEP,   1, 0, 16'h0000);
        r = issue(OP_TICK,    0, 0, 16'h0000);
        r = issue(OP_SLEEP,   1, 0, 16'h0003);
        r = issue(OP_SELECT,  0, 0, 16'h0000);
        r = issue(OP_SELECT,  0, 0, 16'h0000);
        r = issue(OP_SLEEP,   0, 7, 16'hFFFF);
        r = issue(OP_SPARE_A, 15, 7, 16'hFFFF);
        r = issue(OP_SPARE_B, 0, 0, 16'h0000);
        r = issue(OP_TICK,    0, 0, 16'h0000);
        drain();

        // Random phases under several slice lengths, the extremes included.
        slices[0] = 8'd1;
        slices[1] = 8'd255;
        slices[2] = 8'd2;
        slices[3] = SLICE_W'($urandom_range(3, 20));
        slices[4] = 8'd10;
        foreach (slices[k])
        begin
            write_slice(slices[k]);
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
                random_request();
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: offers requests in bursts separated by random gaps. A request
    // stays on the bus until it has been taken.
    // ------------------------------------------------------------------------
    logic req_taken;
    int   burst_left;
    int   gap_left;

    initial
    begin
        req_taken  = 1'b0;
        burst_left = 0;
        gap_left   = 0;
    end

    always @(negedge clk)
    begin
        logic            nxt_valid;
        logic [IN_W-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (rst_n && !(s_tvalid && !req_taken))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() != 0)
            begin
                nxt_data  = pending_requests.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    // End of a burst: choose the next burst and the pause
                    // before it, sometimes with no pause at all.
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between always ready, light and heavy stalling, and
    // once holds off for a long stretch so that the block backs up.
    // ------------------------------------------------------------------------
    int rx_cycle;
    int rx_mode;
    int rx_mode_left;
    int holdoff_left;

    initial
    begin
        rx_cycle     = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        holdoff_left = 0;
    end

    always @(negedge clk)
    begin
        logic rdy;
        rdy = 1'b1;
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_cycle == HOLDOFF_AT)
                holdoff_left = HOLDOFF_LEN;
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(5, 60);
            end
            rx_mode_left--;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rdy = 1'b0;
            end
            else if (rx_mode == 1)
                rdy = ($urandom_range(0, 3) != 0);
            else if (rx_mode == 2)
                rdy = ($urandom_range(0, 3) == 0);
        end
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog, sampled at the rising edge.
    // ------------------------------------------------------------------------
    int idle_cycles;

    initial idle_cycles = 0;

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        req_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[38:0];
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, actual %h", $realtime, got);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                        mismatches++;
                    end
                    if (got.slot !== want.slot)
                    begin
                        $display("%0t: chosen_slot expected %0d actual %0d",
                                 $realtime, want.slot, got.slot);
                        mismatches++;
                    end
                    if (got.id !== want.id)
                    begin
                        $display("%0t: chosen_id expected %h actual %h",
                                 $realtime, want.id, got.id);
                        mismatches++;
                    end
                    if (got.expired !== want.expired)
                    begin
                        $display("%0t: slice_expired expected %0b actual %0b",
                                 $realtime, want.expired, got.expired);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
